// File: src/hmbd_pkg.sv
// Package for the handheld memory bus decoder: transaction structs, target codes,
// memory map bounds and default storage sizes.
// Has no dependencies. Every other file in src uses it.
package hmbd_pkg;

    localparam int WORK_RAM_BYTES = 8192;
    localparam int HIGH_RAM_BYTES = 127;

    // Target codes reported with each result.
    localparam logic [2:0] TGT_CART_ROM = 3'd0;
    localparam logic [2:0] TGT_VRAM     = 3'd1;
    localparam logic [2:0] TGT_CART_RAM = 3'd2;
    localparam logic [2:0] TGT_SPRITE   = 3'd3;
    localparam logic [2:0] TGT_JOYPAD   = 3'd4;
    localparam logic [2:0] TGT_VIDEO_IO = 3'd5;
    localparam logic [2:0] TGT_LOCAL    = 3'd6;

    // Upper bound of each region of the memory map.
    localparam logic [15:0] CART_ROM_END = 16'h7FFF;
    localparam logic [15:0] VRAM_END     = 16'h9FFF;
    localparam logic [15:0] CART_RAM_END = 16'hBFFF;
    localparam logic [15:0] ECHO_END     = 16'hFDFF;
    localparam logic [15:0] SPRITE_END   = 16'hFE9F;
    localparam logic [15:0] UNUSABLE_END = 16'hFEFF;
    localparam logic [15:0] JOYPAD_ADDR  = 16'hFF00;
    localparam logic [15:0] VIDEO_IO_END = 16'hFF7F;
    localparam logic [15:0] HIGH_RAM_END = 16'hFFFE;

    localparam logic [1:0] MODE_OAM_SCAN = 2'd2;
    localparam logic [1:0] MODE_DRAWING  = 2'd3;

    localparam logic       ACT_READ  = 1'b0;
    localparam logic       ACT_WRITE = 1'b1;

    localparam logic [7:0] OPEN_BUS_BYTE = 8'hFF;

    typedef struct packed {
        logic        action;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [1:0]  video_mode;
        logic        dma_busy;
    } t_in;

    typedef struct packed {
        logic [2:0] target;
        logic       forward_access;
        logic [7:0] read_data;
        logic       blocked;
    } t_out;

    // Decode outcome handed from the address decoder to storage and output logic.
    typedef struct packed {
        logic [2:0] target;
        logic       fwd;
        logic       blk;
        logic       sel_wram;
        logic       sel_hram;
        logic       sel_ie;
    } t_dec;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } t_clr_state;

endpackage

// File: src/hmbd_decode.sv
// Address decoder for the handheld memory bus: maps one transaction onto the
// memory map and applies the video mode and DMA blocking rules.
// Depends on hmbd_pkg.
module hmbd_decode (
    input  hmbd_pkg::t_in  i_item,
    output hmbd_pkg::t_dec o_dec
);

    logic [15:0] w_addr;
    logic        w_sprite_blk;

    assign w_addr       = i_item.address;
    assign w_sprite_blk = i_item.dma_busy
                          || (i_item.video_mode == hmbd_pkg::MODE_OAM_SCAN)
                          || (i_item.video_mode == hmbd_pkg::MODE_DRAWING);

    always_comb begin
        o_dec = '0;
        o_dec.target = hmbd_pkg::TGT_LOCAL;
        if (w_addr <= hmbd_pkg::CART_ROM_END) begin
            o_dec.target = hmbd_pkg::TGT_CART_ROM;
            o_dec.fwd    = 1'b1;
        end else if (w_addr <= hmbd_pkg::VRAM_END) begin
            o_dec.target = hmbd_pkg::TGT_VRAM;
            o_dec.blk    = (i_item.video_mode == hmbd_pkg::MODE_DRAWING);
            o_dec.fwd    = (i_item.video_mode != hmbd_pkg::MODE_DRAWING);
        end else if (w_addr <= hmbd_pkg::CART_RAM_END) begin
            o_dec.target = hmbd_pkg::TGT_CART_RAM;
            o_dec.fwd    = 1'b1;
        end else if (w_addr <= hmbd_pkg::ECHO_END) begin
            // Work RAM and its echo share the low address bits.
            o_dec.sel_wram = 1'b1;
        end else if (w_addr <= hmbd_pkg::SPRITE_END) begin
            o_dec.target = hmbd_pkg::TGT_SPRITE;
            o_dec.blk    = w_sprite_blk;
            o_dec.fwd    = !w_sprite_blk;
        end else if (w_addr <= hmbd_pkg::UNUSABLE_END) begin
            // Unusable region: reads float high, writes vanish.
            o_dec.target = hmbd_pkg::TGT_LOCAL;
        end else if (w_addr <= hmbd_pkg::VIDEO_IO_END) begin
            o_dec.target = (w_addr == hmbd_pkg::JOYPAD_ADDR) ? hmbd_pkg::TGT_JOYPAD
                                                             : hmbd_pkg::TGT_VIDEO_IO;
            o_dec.fwd    = 1'b1;
        end else if (w_addr <= hmbd_pkg::HIGH_RAM_END) begin
            o_dec.sel_hram = 1'b1;
        end else begin
            o_dec.sel_ie = 1'b1;
        end
    end

endmodule

// File: src/hmbd_store.sv
// Local storage of the handheld memory bus decoder: work RAM, high RAM and the
// interrupt-enable byte, plus the clearing sweep that zeroes both RAMs after reset.
// Depends on hmbd_pkg.
module hmbd_store #(
    parameter int WORK_RAM_BYTES = hmbd_pkg::WORK_RAM_BYTES,
    parameter int HIGH_RAM_BYTES = hmbd_pkg::HIGH_RAM_BYTES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_access,
    input  logic           i_write,
    input  hmbd_pkg::t_dec i_dec,
    input  logic [15:0]    i_address,
    input  logic [7:0]     i_write_data,
    output logic           o_busy,
    output logic [7:0]     o_read_byte
);

    localparam int WADDR_W = $clog2(WORK_RAM_BYTES);
    localparam int HADDR_W = $clog2(HIGH_RAM_BYTES);

    logic [7:0] r_wram [WORK_RAM_BYTES];
    logic [7:0] r_hram [HIGH_RAM_BYTES];

    hmbd_pkg::t_clr_state r_state, n_state;
    logic [WADDR_W-1:0]   r_clr_idx, n_clr_idx;
    logic [7:0]           r_ie;
    logic [7:0]           r_wram_q;
    logic [7:0]           r_hram_q;
    logic                 r_sel_hram;
    logic                 r_sel_ie;

    logic                 w_clearing;
    logic                 w_wram_we;
    logic [WADDR_W-1:0]   w_wram_waddr;
    logic [7:0]           w_wram_wdata;
    logic                 w_hram_we;
    logic [HADDR_W-1:0]   w_hram_waddr;
    logic [7:0]           w_hram_wdata;

    assign w_clearing = (r_state == hmbd_pkg::ST_CLEAR);
    assign o_busy     = w_clearing;

    // The sweep walks every work RAM row and zeroes high RAM on the way.
    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        case (r_state)
            hmbd_pkg::ST_CLEAR: begin
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == WADDR_W'(WORK_RAM_BYTES - 1)) begin
                    n_state = hmbd_pkg::ST_RUN;
                end
            end
            hmbd_pkg::ST_RUN: begin
                n_state = hmbd_pkg::ST_RUN;
            end
            default: begin
                n_state = hmbd_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        if (w_clearing) begin
            w_wram_we    = 1'b1;
            w_wram_waddr = r_clr_idx;
            w_wram_wdata = '0;
            w_hram_we    = (r_clr_idx < WADDR_W'(HIGH_RAM_BYTES));
            w_hram_waddr = r_clr_idx[HADDR_W-1:0];
            w_hram_wdata = '0;
        end else begin
            w_wram_we    = i_access && i_write && i_dec.sel_wram;
            w_wram_waddr = i_address[WADDR_W-1:0];
            w_wram_wdata = i_write_data;
            w_hram_we    = i_access && i_write && i_dec.sel_hram;
            w_hram_waddr = i_address[HADDR_W-1:0];
            w_hram_wdata = i_write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= hmbd_pkg::ST_CLEAR;
            r_clr_idx <= '0;
            r_ie      <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            if (i_access && i_write && i_dec.sel_ie) begin
                r_ie <= i_write_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wram_we) begin
            r_wram[w_wram_waddr] <= w_wram_wdata;
        end
        r_wram_q <= r_wram[i_address[WADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_hram_we) begin
            r_hram[w_hram_waddr] <= w_hram_wdata;
        end
        r_hram_q <= r_hram[i_address[HADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_sel_hram <= i_dec.sel_hram;
        r_sel_ie   <= i_dec.sel_ie;
    end

    assign o_read_byte = r_sel_ie   ? r_ie :
                         r_sel_hram ? r_hram_q : r_wram_q;

endmodule

// File: src/handheld_memory_bus_decoder.sv
// Top level of the handheld memory bus decoder: accepts CPU byte transactions,
// decodes them and answers from local storage or names the external target.
// Depends on hmbd_pkg, hmbd_decode and hmbd_store.
//
//   Channel   Signals                      Direction  Transfer
//   request   i_start, o_busy, i_item      in         i_start high while o_busy low
//   result    o_valid, o_result            out        one cycle strobe, no backpressure
//
// A transaction accepted at one edge shows its result in the following cycle,
// and a new transaction can be accepted at every edge, one per clock while o_busy is low.
// The result is registered because the work RAM and high RAM reads are
// registered. After reset o_busy stays high while a sweep zeroes work RAM and
// high RAM; nothing stalls after that.
module handheld_memory_bus_decoder #(
    parameter int WORK_RAM_BYTES = hmbd_pkg::WORK_RAM_BYTES,
    parameter int HIGH_RAM_BYTES = hmbd_pkg::HIGH_RAM_BYTES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  hmbd_pkg::t_in  i_item,
    output logic           o_valid,
    output hmbd_pkg::t_out o_result
);

    hmbd_pkg::t_dec w_dec;
    logic           w_accept;
    logic [7:0]     w_read_byte;

    logic           r_valid;
    logic [2:0]     r_target;
    logic           r_fwd;
    logic           r_blk;
    logic           r_zero;
    logic           r_from_mem;

    assign w_accept = i_start && !o_busy;

    hmbd_decode u_decode (
        .i_item (i_item),
        .o_dec  (w_dec)
    );

    hmbd_store #(
        .WORK_RAM_BYTES (WORK_RAM_BYTES),
        .HIGH_RAM_BYTES (HIGH_RAM_BYTES)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_access     (w_accept),
        .i_write      (i_item.action == hmbd_pkg::ACT_WRITE),
        .i_dec        (w_dec),
        .i_address    (i_item.address),
        .i_write_data (i_item.write_data),
        .o_busy       (o_busy),
        .o_read_byte  (w_read_byte)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_target   <= w_dec.target;
        r_fwd      <= w_dec.fwd;
        r_blk      <= w_dec.blk;
        // Writes and forwarded transactions report a zero byte.
        r_zero     <= (i_item.action == hmbd_pkg::ACT_WRITE) || w_dec.fwd;
        r_from_mem <= w_dec.sel_wram || w_dec.sel_hram || w_dec.sel_ie;
    end

    assign o_valid = r_valid;

    always_comb begin
        o_result.target         = r_target;
        o_result.forward_access = r_fwd;
        o_result.blocked        = r_blk;
        if (r_zero) begin
            o_result.read_data = '0;
        end else if (r_from_mem) begin
            o_result.read_data = w_read_byte;
        end else begin
            o_result.read_data = hmbd_pkg::OPEN_BUS_BYTE;
        end
    end

    a_valid_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy))
        else $error("result strobe without an accepted transaction");

    a_fwd_blk_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_result.forward_access && o_result.blocked))
        else $error("transaction both forwarded and blocked");

    a_blk_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.blocked) |->
            (o_result.target == hmbd_pkg::TGT_VRAM || o_result.target == hmbd_pkg::TGT_SPRITE))
        else $error("blocked transaction outside VRAM or sprite RAM");

    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy |=> !o_busy)
        else $error("busy rose again after the clearing sweep");

    a_fwd_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.forward_access) |-> (o_result.read_data == 8'h00))
        else $error("forwarded transaction returned local data");

endmodule
